// ===== sv/sorted_priority_queue_assert.svh =====
// Assertion macros used by the sorted priority queue datapath.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define SPQ_ASSERT(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sorted_priority_queue: invariant violated");

// Check that an antecedent implies a consequent in the next cycle.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_priority_queue: sequence check failed");

`endif

// ===== sv/spq_pkg.sv =====
// Types, codes and constants for the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned TAG_BITS      = 32;
  localparam int unsigned PRIORITY_BITS = 16;
  localparam int unsigned OCC_BITS      = 5;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    op_e                              operation;
    logic [TAG_BITS-1:0]              tag;
    logic signed [PRIORITY_BITS-1:0]  priority_req;
  } spq_req_t;

  typedef struct packed {
    status_e                          status;
    logic [TAG_BITS-1:0]              out_tag;
    logic signed [PRIORITY_BITS-1:0]  out_priority;
    logic [OCC_BITS-1:0]              occupancy;
  } spq_rsp_t;

  typedef struct packed {
    logic load_req;
    logic execute;
  } ctrl_cmd_t;

endpackage

// ===== sv/spq_ctrl.sv =====
// Control state machine: request capture, execution and output handshake.
`timescale 1ns / 1ps
module spq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spq_pkg::ctrl_cmd_t cmd_o
);

  spq_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            fire;

  assign accept = in_valid_i && (state_q == spq_pkg::S_IDLE);
  // Execute once the output register is free or being drained.
  assign fire   = (state_q == spq_pkg::S_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      spq_pkg::S_IDLE: begin
        if (accept) state_d = spq_pkg::S_EXEC;
      end
      spq_pkg::S_EXEC: begin
        if (fire) state_d = spq_pkg::S_IDLE;
      end
      default: state_d = spq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.load_req = 1'b0;
    cmd_o.execute  = 1'b0;
    out_valid_d   = out_valid_q && !out_ready_i;
    case (state_q)
      spq_pkg::S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = accept;
      end
      spq_pkg::S_EXEC: begin
        cmd_o.execute = fire;
        if (fire) out_valid_d = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/spq_datapath.sv =====
// Sorted cell array with parallel compare, insert and shift, plus result register.
`timescale 1ns / 1ps
`include "sorted_priority_queue_assert.svh"
module spq_datapath #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spq_pkg::ctrl_cmd_t cmd_i,
  input  spq_pkg::spq_req_t  req_i,
  output spq_pkg::spq_rsp_t  rsp_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned TW   = spq_pkg::TAG_BITS;
  localparam int unsigned PW   = spq_pkg::PRIORITY_BITS;

  spq_pkg::spq_req_t  req_q;
  spq_pkg::spq_rsp_t  rsp_q, rsp_d;
  logic [CntW-1:0]    count_q, count_d;

  logic [TW-1:0]        tag_q [CAPACITY];
  logic [TW-1:0]        tag_d [CAPACITY];
  logic signed [PW-1:0] pri_q [CAPACITY];
  logic signed [PW-1:0] pri_d [CAPACITY];

  logic [CAPACITY-1:0]  valid;
  logic [CAPACITY-1:0]  gt;
  logic [CAPACITY-1:0]  gt_prev;
  logic [TW-1:0]        up_tag [CAPACITY];
  logic signed [PW-1:0] up_pri [CAPACITY];
  logic [TW-1:0]        dn_tag [CAPACITY];
  logic signed [PW-1:0] dn_pri [CAPACITY];
  logic                 full;
  logic                 empty;
  logic                 enq_ok;

  // Per-cell compare against the pending request.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i] = CntW'(i) < count_q;
      gt[i]    = valid[i] && (pri_q[i] > req_q.priority_req);
    end
  end

  // Neighbor taps: each cell sees the one above and below it, with zeros past either end.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign gt_prev[g] = 1'b0;
      assign up_tag[g]  = '0;
      assign up_pri[g]  = '0;
    end else begin : g_rest
      assign gt_prev[g] = gt[g-1];
      assign up_tag[g]  = tag_q[g-1];
      assign up_pri[g]  = pri_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign dn_tag[g] = '0;
      assign dn_pri[g] = '0;
    end else begin : g_inner
      assign dn_tag[g] = tag_q[g+1];
      assign dn_pri[g] = pri_q[g+1];
    end
  end

  assign full   = count_q == CntW'(CAPACITY);
  assign empty  = count_q == '0;
  assign enq_ok = cmd_i.execute && !full && (req_q.operation == spq_pkg::OP_ENQUEUE);

  always_comb begin
    tag_d   = tag_q;
    pri_d   = pri_q;
    count_d = count_q;
    rsp_d   = rsp_q;
    if (cmd_i.execute) begin
      rsp_d.status       = spq_pkg::ST_DONE;
      rsp_d.out_tag      = '0;
      rsp_d.out_priority = '0;
      if (req_q.operation == spq_pkg::OP_ENQUEUE) begin
        if (full) begin
          rsp_d.status = spq_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (gt_prev[i]) begin
              tag_d[i] = up_tag[i];
              pri_d[i] = up_pri[i];
            end else if (gt[i] || (CntW'(i) == count_q)) begin
              tag_d[i] = req_q.tag;
              pri_d[i] = req_q.priority_req;
            end
          end
          count_d = count_q + CntW'(1);
        end
      end else begin
        if (empty) begin
          rsp_d.status = spq_pkg::ST_EMPTY;
        end else begin
          rsp_d.out_tag      = tag_q[0];
          rsp_d.out_priority = pri_q[0];
          for (int i = 0; i < CAPACITY; i++) begin
            tag_d[i] = dn_tag[i];
            pri_d[i] = dn_pri[i];
          end
          count_d = count_q - CntW'(1);
        end
      end
      rsp_d.occupancy = spq_pkg::OCC_BITS'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    rsp_q <= rsp_d;
    tag_q <= tag_d;
    pri_q <= pri_d;
  end

  assign rsp_o = rsp_q;

  `SPQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(CAPACITY))
  `SPQ_ASSERT(a_front_order, clk_i, rst_ni, !valid[1] || (pri_q[0] <= pri_q[1]))
  `SPQ_ASSERT_NEXT(a_enq_grows, clk_i, rst_ni, enq_ok, count_q == $past(count_q) + CntW'(1))

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: controller plus cell datapath.
`timescale 1ns / 1ps
//
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   in_data_i  (spq_req_t)
// out      output     out_valid_o / out_ready_i out_data_o (spq_rsp_t)
//
// Each request is captured in S_IDLE; in S_EXEC all cells are then compared and
// updated in parallel and the result register is loaded.
// The execute cycle waits while a previous result sits unclaimed in the
// result register; in_ready_o stays low during that wait, so at most one
// request is held beside one waiting result.
// Reset clears the entry count and handshake state; cell contents are left
// as they are and are never read before being written.
// CAPACITY must fit the occupancy field of the result.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spq_pkg::spq_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spq_pkg::spq_rsp_t out_data_o
);

  // Commands from the controller to the datapath: capture and execute.
  spq_pkg::ctrl_cmd_t cmd;

  // Controller: request capture, execution timing and output valid.
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Datapath: sorted cell array, insertion and removal, result register.
  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_data_i),
    .rsp_o  (out_data_o)
  );

endmodule
